// File: hw/rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg: types and constants of the source text lexer
// Token kinds, error codes, lexer modes and the request payload structs.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam logic [3:0] TK_NONE     = 4'd0;
  localparam logic [3:0] TK_KEYWORD  = 4'd1;
  localparam logic [3:0] TK_ID       = 4'd2;
  localparam logic [3:0] TK_INT      = 4'd3;
  localparam logic [3:0] TK_FLOAT    = 4'd4;
  localparam logic [3:0] TK_ARITH    = 4'd5;
  localparam logic [3:0] TK_REL      = 4'd6;
  localparam logic [3:0] TK_ASSIGN   = 4'd7;
  localparam logic [3:0] TK_NEG      = 4'd8;
  localparam logic [3:0] TK_GROUP    = 4'd9;
  localparam logic [3:0] TK_LOGIC    = 4'd10;
  localparam logic [3:0] TK_SEP      = 4'd11;
  localparam logic [3:0] TK_STRING   = 4'd12;

  localparam logic [3:0] ER_NONE     = 4'd0;
  localparam logic [3:0] ER_BAD_CHAR = 4'd1;
  localparam logic [3:0] ER_FLOAT    = 4'd2;
  localparam logic [3:0] ER_DBL_REL  = 4'd3;
  localparam logic [3:0] ER_AND      = 4'd4;
  localparam logic [3:0] ER_OR       = 4'd5;
  localparam logic [3:0] ER_NL_STR   = 4'd6;
  localparam logic [3:0] ER_OPEN_STR = 4'd7;
  localparam logic [3:0] ER_OPEN_CMT = 4'd8;

  localparam logic [7:0] MAX_ERRORS_RESET = 8'd100;
  localparam int         KW_COUNT = 15;
  localparam int         KW_MAX   = 8;

  typedef enum logic [8:0] {
    M_START   = 9'b000000001,
    M_ID      = 9'b000000010,
    M_INT     = 9'b000000100,
    M_FLOAT   = 9'b000001000,
    M_ARITH   = 9'b000010000,
    M_REL     = 9'b000100000,
    M_LOGIC   = 9'b001000000,
    M_STRING  = 9'b010000000,
    M_COMMENT = 9'b100000000
  } mode_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [3:0]  error_code;
    logic [15:0] line_number;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic        last_result;
  } out_req_t;

  typedef logic [KW_MAX*8-1:0] kw_text_t;

  // keyword table, first byte in the low bits
  function automatic kw_text_t kw_text(input int i);
    unique case (i)
      0:  kw_text = kw_text_t'({"rav"});
      1:  kw_text = kw_text_t'({"tni"});
      2:  kw_text = kw_text_t'({"taolf"});
      3:  kw_text = kw_text_t'({"loob"});
      4:  kw_text = kw_text_t'({"gnirts"});
      5:  kw_text = kw_text_t'({"noitcnuf"});
      6:  kw_text = kw_text_t'({"niam"});
      7:  kw_text = kw_text_t'({"fi"});
      8:  kw_text = kw_text_t'({"esle"});
      9:  kw_text = kw_text_t'({"elihw"});
      10: kw_text = kw_text_t'({"rof"});
      11: kw_text = kw_text_t'({"hctiws"});
      12: kw_text = kw_text_t'({"tluafed"});
      13: kw_text = kw_text_t'({"nruter"});
      default: kw_text = kw_text_t'({"esac"});
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input int i);
    unique case (i)
      0, 1, 10:       kw_len = 4'd3;
      2, 9:           kw_len = 4'd5;
      3, 6, 8, 14:    kw_len = 4'd4;
      4, 11, 13:      kw_len = 4'd6;
      5:              kw_len = 4'd8;
      7:              kw_len = 4'd2;
      default:        kw_len = 4'd7;
    endcase
  endfunction

endpackage

// File: hw/rtl/source_text_lexer.sv
// ----------------------------------------------------------------------------
// source_text_lexer: byte-serial lexical analyser
// Takes one source byte per request and gives token or error requests.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while in_stall is low: the lexer state, counters
// and identifier bytes update in a single pass of logic from the accepted byte,
// and the up to two results that byte causes are held in a small result queue.
// Input is stalled only while the queue cannot take a worst-case burst, so with
// the output never stalled one-result items are not held up; runs of two-result
// items are paced by the output, where results leave one per cycle while
// out_stall is low. Keywords are found by a parallel compare against a fixed
// table of fifteen words. max_errors must be written through the cfg channel
// only while the block is idle; the block does not enforce this.
module source_text_lexer
  import stl_pkg::*;
#(
  parameter int MAX_ID_LEN = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_req_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_req_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int LW = $clog2(MAX_ID_LEN);
  localparam int QD = 4;

  // lexer state
  logic [7:0]  max_errors;
  mode_t       mode, mode_next;
  logic [7:0]  ident [MAX_ID_LEN];
  logic [15:0] tok_len, tok_len_next;
  logic [23:0] tok_begin, tok_begin_next;
  logic [23:0] byte_off, byte_off_next;
  logic [15:0] line_cnt, line_cnt_next;
  logic [7:0]  prev, prev_next;
  logic        skip, skip_next;
  logic [7:0]  err_cnt, err_cnt_next;

  // result queue
  out_req_t    q [QD];
  logic [1:0]  q_rd, q_wr;
  logic [2:0]  q_cnt;

  logic        acc, pop;
  out_req_t    r [3];
  logic [1:0]  n_res;
  logic        id_wr;
  logic [LW-1:0] id_idx;

  assign acc       = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign out_valid = q_cnt != 3'd0;
  assign out_data  = q[q_rd];
  // room for a worst-case burst of results after this cycle's pop
  assign in_stall  = q_cnt > (pop ? 3'd3 : 3'd2);
  assign cfg_ready = 1'b1;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // keyword match over the stored identifier
  logic kw_hit;
  always_comb begin
    logic eq;
    kw_text_t w;
    kw_hit = 1'b0;
    for (int i = 0; i < KW_COUNT; i++) begin
      eq = tok_len == 16'(kw_len(i)) && 16'(kw_len(i)) <= 16'(MAX_ID_LEN);
      w = kw_text(i);
      for (int j = 0; j < KW_MAX; j++) begin
        if (j < int'(kw_len(i)) && j < MAX_ID_LEN &&
            ident[j] != w[j*8 +: 8]) begin
          eq = 1'b0;
        end
      end
      if (eq) kw_hit = 1'b1;
    end
  end

  always_comb begin
    logic [7:0]  c;
    logic [23:0] off;
    logic        again;
    logic [15:0] lc;
    logic [3:0]  k;
    c     = in_data.char_byte;
    off   = byte_off;
    again = 1'b0;
    mode_next      = mode;
    tok_len_next   = tok_len;
    tok_begin_next = tok_begin;
    byte_off_next  = byte_off;
    line_cnt_next  = line_cnt;
    prev_next      = prev;
    skip_next      = skip;
    err_cnt_next   = err_cnt;
    n_res          = 2'd0;
    id_wr          = 1'b0;
    id_idx         = '0;
    k              = TK_NONE;
    for (int i = 0; i < 3; i++) r[i] = '0;
    lc = line_cnt;

    if (err_cnt > max_errors) begin
      if (in_data.end_of_text) begin
        mode_next = M_START; tok_len_next = '0; tok_begin_next = '0;
        byte_off_next = '0; line_cnt_next = 16'd1; prev_next = '0;
        skip_next = 1'b0; err_cnt_next = '0;
      end
    end else if (in_data.end_of_text) begin
      // flush the pending token, then re-arm
      unique case (mode)
        M_ID:    begin k = kw_hit ? TK_KEYWORD : TK_ID; end
        M_INT:   k = TK_INT;
        M_ARITH: k = TK_ARITH;
        M_REL:   k = prev == "=" ? TK_ASSIGN : prev == "!" ? TK_NEG : TK_REL;
        default: k = TK_NONE;
      endcase
      if (k != TK_NONE) begin
        r[0] = '{k, ER_NONE, lc, tok_begin, tok_len, 1'b0};
        n_res = 2'd1;
      end else if (mode != M_START) begin
        r[0] = '{TK_NONE,
                 mode == M_FLOAT ? (prev == "." ? ER_FLOAT : ER_NONE) :
                 mode == M_LOGIC ? (prev == "&" ? ER_AND : ER_OR) :
                 mode == M_STRING ? ER_OPEN_STR : ER_OPEN_CMT,
                 lc, tok_begin, tok_len, 1'b0};
        if (mode == M_FLOAT && prev != ".") r[0].token_kind = TK_FLOAT;
        else if (err_cnt != 8'hFF) err_cnt_next = err_cnt + 8'd1;
        n_res = 2'd1;
      end
      mode_next = M_START; tok_len_next = '0; tok_begin_next = '0;
      byte_off_next = '0; line_cnt_next = 16'd1; prev_next = '0;
      skip_next = 1'b0; err_cnt_next = '0;
    end else begin
      byte_off_next = off + 24'd1;
      if (skip) begin
        skip_next = 1'b0;
        if (mode == M_COMMENT && tok_len != 16'hFFFF) tok_len_next = tok_len + 16'd1;
      end else begin
        unique case (mode)
          M_ID: begin
            if (is_alpha(c) || is_digit(c) || c == "_") begin
              if (tok_len < 16'(MAX_ID_LEN)) begin
                id_wr = 1'b1; id_idx = tok_len[LW-1:0];
              end
              if (tok_len != 16'hFFFF) tok_len_next = tok_len + 16'd1;
            end else begin
              r[0] = '{kw_hit ? TK_KEYWORD : TK_ID, ER_NONE, lc, tok_begin,
                       tok_len, 1'b0};
              n_res = 2'd1; again = 1'b1;
            end
          end
          M_INT: begin
            if (is_digit(c)) begin
              if (tok_len != 16'hFFFF) tok_len_next = tok_len + 16'd1;
            end else if (c == ".") begin
              if (tok_len != 16'hFFFF) tok_len_next = tok_len + 16'd1;
              prev_next = c; mode_next = M_FLOAT;
            end else begin
              r[0] = '{TK_INT, ER_NONE, lc, tok_begin, tok_len, 1'b0};
              n_res = 2'd1; again = 1'b1;
            end
          end
          M_FLOAT: begin
            if (is_digit(c)) begin
              if (tok_len != 16'hFFFF) tok_len_next = tok_len + 16'd1;
              prev_next = c;
            end else begin
              if (prev == ".") begin
                r[0] = '{TK_NONE, ER_FLOAT, lc, tok_begin, tok_len, 1'b0};
                if (err_cnt != 8'hFF) err_cnt_next = err_cnt + 8'd1;
              end else begin
                r[0] = '{TK_FLOAT, ER_NONE, lc, tok_begin, tok_len, 1'b0};
              end
              n_res = 2'd1; again = 1'b1;
            end
          end
          M_ARITH: begin
            if ((c == "+" || c == "-") && c == prev) begin
              r[0] = '{TK_ARITH, ER_NONE, lc, tok_begin,
                       tok_len == 16'hFFFF ? tok_len : tok_len + 16'd1, 1'b0};
              n_res = 2'd1; mode_next = M_START;
            end else if (c == "*" && prev == "/") begin
              if (tok_len != 16'hFFFF) tok_len_next = tok_len + 16'd1;
              prev_next = c; mode_next = M_COMMENT;
            end else begin
              r[0] = '{TK_ARITH, ER_NONE, lc, tok_begin, tok_len, 1'b0};
              n_res = 2'd1; again = 1'b1;
            end
          end
          M_REL: begin
            if (c == "=") begin
              r[0] = '{TK_REL, ER_NONE, lc, tok_begin,
                       tok_len == 16'hFFFF ? tok_len : tok_len + 16'd1, 1'b0};
              n_res = 2'd1; mode_next = M_START;
            end else if (c == prev) begin
              r[0] = '{TK_NONE, ER_DBL_REL, lc, tok_begin, tok_len, 1'b0};
              if (err_cnt != 8'hFF) err_cnt_next = err_cnt + 8'd1;
              n_res = 2'd1; again = 1'b1;
            end else begin
              r[0] = '{prev == "=" ? TK_ASSIGN : prev == "!" ? TK_NEG : TK_REL,
                       ER_NONE, lc, tok_begin, tok_len, 1'b0};
              n_res = 2'd1; again = 1'b1;
            end
          end
          M_LOGIC: begin
            if (c == prev) begin
              r[0] = '{TK_LOGIC, ER_NONE, lc, tok_begin,
                       tok_len == 16'hFFFF ? tok_len : tok_len + 16'd1, 1'b0};
              n_res = 2'd1; mode_next = M_START;
            end else begin
              r[0] = '{TK_NONE, prev == "&" ? ER_AND : ER_OR, lc, tok_begin,
                       tok_len, 1'b0};
              if (err_cnt != 8'hFF) err_cnt_next = err_cnt + 8'd1;
              n_res = 2'd1; again = 1'b1;
            end
          end
          M_STRING: begin
            if (c == 8'h0D) begin
              r[0] = '{TK_NONE, ER_NL_STR, lc, tok_begin, tok_len, 1'b0};
              if (err_cnt != 8'hFF) err_cnt_next = err_cnt + 8'd1;
              n_res = 2'd1; mode_next = M_START;
              if (lc != 16'hFFFF) line_cnt_next = lc + 16'd1;
              skip_next = 1'b1;
            end else begin
              if (tok_len != 16'hFFFF) tok_len_next = tok_len + 16'd1;
              if (c == 8'h22) begin
                r[0] = '{TK_STRING, ER_NONE, lc, tok_begin, tok_len_next, 1'b0};
                n_res = 2'd1; mode_next = M_START;
              end
            end
          end
          M_COMMENT: begin
            if (tok_len != 16'hFFFF) tok_len_next = tok_len + 16'd1;
            if (c == "/" && prev == "*") begin
              r[0] = '{TK_STRING, ER_NONE, lc, tok_begin, tok_len_next, 1'b0};
              n_res = 2'd1; mode_next = M_START;
            end else begin
              prev_next = c;
              if (c == 8'h0D) begin
                if (lc != 16'hFFFF) line_cnt_next = lc + 16'd1;
                skip_next = 1'b1;
              end
            end
          end
          default: again = 1'b1;
        endcase

        // byte handled from the start state
        if (again) begin
          mode_next = M_START;
          if (is_alpha(c) || c == "_") begin
            mode_next = M_ID; tok_begin_next = off; tok_len_next = 16'd1;
            prev_next = c; id_wr = 1'b1; id_idx = '0;
          end else if (is_digit(c)) begin
            mode_next = M_INT; tok_begin_next = off; tok_len_next = 16'd1;
            prev_next = c;
          end else if (c == "<" || c == ">" || c == "!" || c == "=") begin
            mode_next = M_REL; tok_begin_next = off; tok_len_next = 16'd1;
            prev_next = c;
          end else if (c == "+" || c == "-" || c == "*" || c == "/" ||
                       c == "^" || c == "%") begin
            mode_next = M_ARITH; tok_begin_next = off; tok_len_next = 16'd1;
            prev_next = c;
          end else if (c == "(" || c == ")" || c == "{" || c == "}" ||
                       c == "[" || c == "]") begin
            r[n_res] = '{TK_GROUP, ER_NONE, lc, off, 16'd1, 1'b0};
            n_res = n_res + 2'd1;
          end else if (c == "&" || c == "|") begin
            mode_next = M_LOGIC; tok_begin_next = off; tok_len_next = 16'd1;
            prev_next = c;
          end else if (c == 8'h22) begin
            mode_next = M_STRING; tok_begin_next = off; tok_len_next = 16'd1;
            prev_next = c;
          end else if (c == ":" || c == "," || c == ";") begin
            r[n_res] = '{TK_SEP, ER_NONE, lc, off, 16'd1, 1'b0};
            n_res = n_res + 2'd1;
          end else if (c == 8'd9 || c == 8'd32) begin
            // blank
          end else if (c == 8'h0D) begin
            if (lc != 16'hFFFF) line_cnt_next = lc + 16'd1;
            skip_next = 1'b1;
          end else begin
            r[n_res] = '{TK_NONE, ER_BAD_CHAR, lc, off, 16'd1, 1'b0};
            if (err_cnt_next != 8'hFF) err_cnt_next = err_cnt_next + 8'd1;
            n_res = n_res + 2'd1;
          end
        end
      end
    end
    if (n_res != 2'd0) r[n_res - 2'd1].last_result = 1'b1;
  end

  // identifier bytes, no reset needed
  always_ff @(posedge clk) begin
    if (acc && id_wr) ident[id_idx] <= in_data.char_byte;
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n_res) q[q_wr + 2'(i)] <= r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_errors <= MAX_ERRORS_RESET;
      mode       <= M_START;
      tok_len    <= '0;
      tok_begin  <= '0;
      byte_off   <= '0;
      line_cnt   <= 16'd1;
      prev       <= '0;
      skip       <= 1'b0;
      err_cnt    <= '0;
      q_rd       <= '0;
      q_wr       <= '0;
      q_cnt      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) max_errors <= cfg_data;
      if (acc) begin
        mode      <= mode_next;
        tok_len   <= tok_len_next;
        tok_begin <= tok_begin_next;
        byte_off  <= byte_off_next;
        line_cnt  <= line_cnt_next;
        prev      <= prev_next;
        skip      <= skip_next;
        err_cnt   <= err_cnt_next;
        q_wr      <= q_wr + n_res;
      end
      if (pop) q_rd <= q_rd + 2'd1;
      q_cnt <= q_cnt + (acc ? 3'(n_res) : 3'd0) - 3'(pop);
    end
  end

endmodule
